// ===== sv/tbhf_pkg.sv =====
// ----------------------------------------------------------------------------
// tbhf_pkg: shared types and constants of the two-byte header framer
// Holds the register indexes, field widths, result word layout and the
// depth of the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tbhf_pkg;

  // Field widths.
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;

  // Longest frame the length counter is built for.
  localparam logic [LEN_W-1:0] MAX_FRAME_LEN = LEN_W'(64);
  localparam logic [LEN_W-1:0] MIN_FRAME_LEN = LEN_W'(2);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_FIRST  = 2'd0,
    REG_HEADER_SECOND = 2'd1,
    REG_FRAME_LENGTH  = 2'd2
  } cfg_reg_t;

  // Configuration reset values.
  localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'd170;
  localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'd85;
  localparam logic [LEN_W-1:0]  FRAME_LENGTH_RST  = 7'd8;

  // Result queue geometry. One accepted byte adds at most two words.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One result word.
  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic              frame_start;
    logic              frame_end;
  } result_t;

  // Words produced by one accepted byte, handed from the core to the queue.
  typedef struct packed {
    logic    first_valid;
    logic    second_valid;
    result_t first_word;
    result_t second_word;
  } push_t;

endpackage

`default_nettype wire

// ===== sv/two_byte_header_fixed_length_framer.sv =====
// ----------------------------------------------------------------------------
// two_byte_header_fixed_length_framer: fixed-length frame extractor
// Hunts a byte stream for a two-byte header and passes on frames of a
// programmable total length, marking their first and last words.
// ----------------------------------------------------------------------------
// Output: words wait in a registered queue; a header match enters both together.
// Throughput: one byte per cycle while the queue has room. The output drains one
//   word per cycle while out_stall is low, from a four-word queue, and input
//   stalls while the queue holds three or more words.
// Reset (rst, synchronous): back to hunting, queue emptied, and the header and
//   length registers return to 0xAA, 0x55 and 8.
`default_nettype none

module two_byte_header_fixed_length_framer (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Byte input channel.
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [tbhf_pkg::BYTE_W-1:0]       byte_in,
  // Frame output channel.
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [tbhf_pkg::BYTE_W-1:0]            frame_byte,
  output logic                                   frame_start,
  output logic                                   frame_end,
  // Configuration write channel.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tbhf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tbhf_pkg::BYTE_W-1:0]       cfg_data
);

  logic [tbhf_pkg::BYTE_W-1:0] header_first;
  logic [tbhf_pkg::BYTE_W-1:0] header_second;
  logic [tbhf_pkg::LEN_W-1:0]  frame_length;
  logic                        in_accept;
  logic                        out_pop;
  logic                        queue_full;
  tbhf_pkg::push_t             push;
  tbhf_pkg::result_t           head;

  // Configuration writes are always taken. An index past the last register
  // is accepted and ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= tbhf_pkg::HEADER_FIRST_RST;
      header_second <= tbhf_pkg::HEADER_SECOND_RST;
      frame_length  <= tbhf_pkg::FRAME_LENGTH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        tbhf_pkg::REG_HEADER_FIRST:  header_first  <= cfg_data;
        tbhf_pkg::REG_HEADER_SECOND: header_second <= cfg_data;
        tbhf_pkg::REG_FRAME_LENGTH:  frame_length  <= cfg_data[tbhf_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // A byte is taken whenever the queue is sure to have room for the two words
  // a header match can produce. The stall depends only on registered state.
  assign in_stall  = queue_full;
  assign in_accept = in_valid && !queue_full;

  // The output word is the head of the queue; a pop happens on each
  // completed output handshake.
  assign out_pop = out_valid && !out_stall;

  tbhf_core u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (in_accept),
    .byte_in       (byte_in),
    .header_first  (header_first),
    .header_second (header_second),
    .frame_length  (frame_length),
    .push          (push)
  );

  tbhf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (out_pop),
    .not_empty (out_valid),
    .full      (queue_full),
    .head      (head)
  );

  assign frame_byte  = head.frame_byte;
  assign frame_start = head.frame_start;
  assign frame_end   = head.frame_end;

endmodule

`default_nettype wire

// ===== sv/tbhf_core.sv =====
// ----------------------------------------------------------------------------
// tbhf_core: header hunt and frame counting
// Updates the hunt/collect state for each accepted byte and produces the
// zero, one or two result words that byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module tbhf_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         accept,
  input  wire logic [tbhf_pkg::BYTE_W-1:0]  byte_in,
  input  wire logic [tbhf_pkg::BYTE_W-1:0]  header_first,
  input  wire logic [tbhf_pkg::BYTE_W-1:0]  header_second,
  input  wire logic [tbhf_pkg::LEN_W-1:0]   frame_length,
  output tbhf_pkg::push_t                   push
);

  logic                        collecting;
  logic                        collecting_next;
  logic                        prev_was_header_first;
  logic                        prev_was_header_first_next;
  logic [tbhf_pkg::LEN_W-1:0]  bytes_emitted;
  logic [tbhf_pkg::LEN_W-1:0]  bytes_emitted_next;
  logic [tbhf_pkg::LEN_W-1:0]  eff_len;
  logic [tbhf_pkg::LEN_W-1:0]  emitted_inc;
  logic                        body_last;
  logic                        header_last;

  // Length clamped into the supported range.
  always_comb begin
    eff_len = frame_length;
    if (frame_length < tbhf_pkg::MIN_FRAME_LEN) begin
      eff_len = tbhf_pkg::MIN_FRAME_LEN;
    end else if (frame_length > tbhf_pkg::MAX_FRAME_LEN) begin
      eff_len = tbhf_pkg::MAX_FRAME_LEN;
    end
  end

  assign emitted_inc = bytes_emitted + tbhf_pkg::LEN_W'(1);
  assign body_last   = (emitted_inc >= eff_len);
  assign header_last = (eff_len <= tbhf_pkg::MIN_FRAME_LEN);

  always_comb begin
    collecting_next            = collecting;
    prev_was_header_first_next = prev_was_header_first;
    bytes_emitted_next         = bytes_emitted;
    push                       = '0;
    push.first_word.frame_byte  = byte_in;
    push.second_word.frame_byte = byte_in;

    if (accept) begin
      if (collecting) begin
        // Body byte of a frame.
        push.first_valid          = 1'b1;
        push.first_word.frame_end = body_last;
        bytes_emitted_next        = emitted_inc;
        if (body_last) begin
          collecting_next            = 1'b0;
          bytes_emitted_next         = '0;
          prev_was_header_first_next = 1'b0;
        end
      end else if (prev_was_header_first && (byte_in == header_second)) begin
        // Header found: both header bytes go out together.
        push.first_valid             = 1'b1;
        push.first_word.frame_byte   = header_first;
        push.first_word.frame_start  = 1'b1;
        push.second_valid            = 1'b1;
        push.second_word.frame_end   = header_last;
        prev_was_header_first_next   = 1'b0;
        collecting_next              = !header_last;
        bytes_emitted_next           = header_last ? '0 : tbhf_pkg::MIN_FRAME_LEN;
      end else begin
        prev_was_header_first_next = (byte_in == header_first);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting            <= 1'b0;
      prev_was_header_first <= 1'b0;
      bytes_emitted         <= '0;
    end else begin
      collecting            <= collecting_next;
      prev_was_header_first <= prev_was_header_first_next;
      bytes_emitted         <= bytes_emitted_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tbhf_queue.sv =====
// ----------------------------------------------------------------------------
// tbhf_queue: short result queue
// A shift queue that takes up to two words per cycle and hands out one word
// per cycle at its head when popped.
// ----------------------------------------------------------------------------
`default_nettype none

module tbhf_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire tbhf_pkg::push_t      push,
  input  wire logic                 pop,
  output logic                      not_empty,
  output logic                      full,
  output tbhf_pkg::result_t         head
);

  tbhf_pkg::result_t                    q      [tbhf_pkg::QUEUE_DEPTH];
  tbhf_pkg::result_t                    q_next [tbhf_pkg::QUEUE_DEPTH];
  logic [tbhf_pkg::QUEUE_CNT_W-1:0]     count;
  logic [tbhf_pkg::QUEUE_CNT_W-1:0]     count_next;

  assign not_empty = (count != '0);
  assign head      = q[0];
  // Room for two more words must be certain before a byte is taken.
  assign full = (count > tbhf_pkg::QUEUE_CNT_W'(tbhf_pkg::QUEUE_DEPTH - 2));

  always_comb begin
    q_next     = q;
    count_next = count;
    if (pop) begin
      for (int i = 0; i < tbhf_pkg::QUEUE_DEPTH - 1; i++) begin
        q_next[i] = q[i+1];
      end
      count_next = count_next - tbhf_pkg::QUEUE_CNT_W'(1);
    end
    if (push.first_valid) begin
      q_next[count_next[tbhf_pkg::QUEUE_IDX_W-1:0]] = push.first_word;
      count_next = count_next + tbhf_pkg::QUEUE_CNT_W'(1);
    end
    if (push.second_valid) begin
      q_next[count_next[tbhf_pkg::QUEUE_IDX_W-1:0]] = push.second_word;
      count_next = count_next + tbhf_pkg::QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_two_byte_header_fixed_length_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_byte_header_fixed_length_framer: self-checking bench for the framer
// Streams bytes into the framer and predicts every frame word it should put
// out. Each word taken from the output is checked against the oldest
// prediction. A short directed run comes first, then random phases. Each
// random phase has its own header and length setting and its own pattern of
// sender and receiver stalls.
// ----------------------------------------------------------------------------

module tb_two_byte_header_fixed_length_framer;

  // Index 3 is not decoded by the block, so a write to it must change nothing.
  localparam logic [tbhf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // The receiver holds off this long once, so that the result queue fills and
  // the input side has to stall.
  localparam int HOLD_CYCLES   = 120;
  // Cycles allowed after the last expected word for a byte that is still in
  // flight. A hunting byte causes no word, so this wait also covers it.
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_REPORTS   = 10;
  // Frame bytes generated per random phase. Nine phases, with the noise
  // between frames, give about 800 input bytes.
  localparam int PHASE_GOAL    = 45;

  logic                           clk         = 1'b0;
  logic                           rst         = 1'b1;
  logic                           in_valid    = 1'b0;
  logic [tbhf_pkg::BYTE_W-1:0]    byte_in     = '0;
  logic                           out_stall   = 1'b0;
  logic                           cfg_valid   = 1'b0;
  logic [tbhf_pkg::CFG_IDX_W-1:0] cfg_index   = tbhf_pkg::REG_HEADER_FIRST;
  logic [tbhf_pkg::BYTE_W-1:0]    cfg_data    = '0;
  logic                           in_stall;
  logic                           out_valid;
  logic [tbhf_pkg::BYTE_W-1:0]    frame_byte;
  logic                           frame_start;
  logic                           frame_end;
  logic                           cfg_ready;

  two_byte_header_fixed_length_framer DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .byte_in     (byte_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .frame_byte  (frame_byte),
    .frame_start (frame_start),
    .frame_end   (frame_end),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #2 clk = ~clk;

  // Bytes waiting to be offered, and frame words predicted but not yet seen.
  logic [tbhf_pkg::BYTE_W-1:0] pending_bytes [$];
  tbhf_pkg::result_t           expected_words [$];

  // Stall rates in percent, changed by the stimulus between phases.
  int send_idle_pct = 12;
  int recv_idle_pct = 73;

  // Long receiver hold-off. The stimulus bumps the request count and the
  // receiver process counts the hold down on its own.
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  // Set at each rising edge when the input word was taken there.
  bit byte_taken = 1'b0;
  int err_count  = 0;

  // Bench copy of the register file, starting from the reset values.
  logic [tbhf_pkg::BYTE_W-1:0] hdr_first_cfg  = tbhf_pkg::HEADER_FIRST_RST;
  logic [tbhf_pkg::BYTE_W-1:0] hdr_second_cfg = tbhf_pkg::HEADER_SECOND_RST;
  logic [tbhf_pkg::LEN_W-1:0]  flen_cfg       = tbhf_pkg::FRAME_LENGTH_RST;

  // Bench copy of the framer state.
  bit                          in_frame  = 1'b0;
  bit                          saw_first = 1'b0;
  logic [tbhf_pkg::LEN_W-1:0]  sent_cnt  = '0;

  // The programmed length is clamped to the range the counter supports.
  function automatic logic [tbhf_pkg::LEN_W-1:0] frame_len_now();
    if (flen_cfg < tbhf_pkg::MIN_FRAME_LEN) return tbhf_pkg::MIN_FRAME_LEN;
    if (flen_cfg > tbhf_pkg::MAX_FRAME_LEN) return tbhf_pkg::MAX_FRAME_LEN;
    return flen_cfg;
  endfunction

  function automatic logic [tbhf_pkg::BYTE_W-1:0] rand_byte();
    return tbhf_pkg::BYTE_W'($urandom_range(0, 255));
  endfunction

  // Works out the frame words that one accepted byte produces and queues them.
  task automatic predict_byte(input logic [tbhf_pkg::BYTE_W-1:0] b);
    logic [tbhf_pkg::LEN_W-1:0] len;
    tbhf_pkg::result_t          w;
    len = frame_len_now();
    if (in_frame) begin
      // Inside a frame every byte passes through. The length is read again
      // on each byte, so lowering it mid-frame ends the frame on the next one.
      sent_cnt      = sent_cnt + 1'b1;
      w.frame_byte  = b;
      w.frame_start = 1'b0;
      w.frame_end   = (sent_cnt >= len);
      expected_words.push_back(w);
      if (w.frame_end) begin
        in_frame  = 1'b0;
        sent_cnt  = '0;
        saw_first = 1'b0;
      end
    end else if (saw_first && b == hdr_second_cfg) begin
      // The header completes: both header bytes go out together. A length
      // of two ends the frame on the second one.
      w.frame_byte  = hdr_first_cfg;
      w.frame_start = 1'b1;
      w.frame_end   = 1'b0;
      expected_words.push_back(w);
      w.frame_byte  = b;
      w.frame_start = 1'b0;
      w.frame_end   = (len <= tbhf_pkg::MIN_FRAME_LEN);
      expected_words.push_back(w);
      saw_first = 1'b0;
      in_frame  = (len > tbhf_pkg::MIN_FRAME_LEN);
      sent_cnt  = in_frame ? tbhf_pkg::MIN_FRAME_LEN : '0;
    end else begin
      // Hunting: a first header byte is remembered even after another one,
      // which finds overlapping patterns such as first, first, second.
      saw_first = (b == hdr_first_cfg);
    end
  endtask

  // Sender. It offers a new word only after the last one was taken or when
  // nothing was offered. Whether it idles does not depend on the stall.
  always @(negedge clk) begin : byte_driver
    if (!in_valid || byte_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        byte_in  <= pending_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver. It stalls at random, except during a requested hold-off.
  always @(negedge clk) begin : frame_receiver
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES - 1;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Monitor. It predicts from each byte taken on the input and checks each
  // word taken on the output against the oldest prediction.
  always @(posedge clk) begin : frame_monitor
    tbhf_pkg::result_t want;
    tbhf_pkg::result_t got;
    byte_taken = !rst && in_valid && !in_stall;
    if (byte_taken) predict_byte(byte_in);
    if (!rst && out_valid && !out_stall) begin
      got = {frame_byte, frame_start, frame_end};
      if (expected_words.size() == 0) begin
        if (err_count < MAX_REPORTS)
          $display("%0t: unexpected frame word: byte %02h start %0b end %0b",
                   $time, got.frame_byte, got.frame_start, got.frame_end);
        err_count++;
      end else begin
        want = expected_words.pop_front();
        if (got.frame_byte !== want.frame_byte || got.frame_start !== want.frame_start ||
            got.frame_end !== want.frame_end) begin
          if (err_count < MAX_REPORTS)
            $display("%0t: frame word mismatch: expected byte %02h start %0b end %0b, got %s",
                     $time, want.frame_byte, want.frame_start, want.frame_end,
                     $sformatf("byte %02h start %0b end %0b",
                               got.frame_byte, got.frame_start, got.frame_end));
          err_count++;
        end
      end
    end
  end

  // Writes one register and records it in the bench copy at the handshake.
  task automatic write_reg(input logic [tbhf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tbhf_pkg::BYTE_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      tbhf_pkg::REG_HEADER_FIRST:  hdr_first_cfg  = data;
      tbhf_pkg::REG_HEADER_SECOND: hdr_second_cfg = data;
      tbhf_pkg::REG_FRAME_LENGTH:  flen_cfg       = data[tbhf_pkg::LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // The sender pauses here until every byte is taken and every predicted
  // word has come. It then lets the block settle.
  task automatic wait_drained();
    @(posedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Hunting noise, with a fair share of first header bytes to leave a
  // pending header behind.
  task automatic add_noise(input int count);
    for (int i = 0; i < count; i++)
      pending_bytes.push_back($urandom_range(0, 4) == 0 ? hdr_first_cfg : rand_byte());
  endtask

  // A header followed by the payload bytes. The payload sometimes repeats
  // the header bytes, which must pass through untouched.
  task automatic add_frame(input int payload);
    int pick;
    pending_bytes.push_back(hdr_first_cfg);
    pending_bytes.push_back(hdr_second_cfg);
    for (int i = 0; i < payload; i++) begin
      pick = $urandom_range(0, 19);
      pending_bytes.push_back(pick == 0 ? hdr_first_cfg :
                              pick == 1 ? hdr_second_cfg : rand_byte());
    end
  endtask

  // One random phase: new headers and length, then mostly well-formed frames
  // with random payload, mixed with noise and broken headers.
  task automatic run_random_phase(input logic [tbhf_pkg::BYTE_W-1:0] len_data,
                                  input bit with_hold);
    int made;
    int pick;
    int len;
    write_reg(tbhf_pkg::REG_HEADER_FIRST, rand_byte());
    // Equal header bytes now and then.
    write_reg(tbhf_pkg::REG_HEADER_SECOND,
              $urandom_range(0, 5) == 0 ? hdr_first_cfg : rand_byte());
    write_reg(tbhf_pkg::REG_FRAME_LENGTH, len_data);
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, rand_byte());
    len = frame_len_now();
    if (with_hold) hold_requests++;
    made = 0;
    while (made < PHASE_GOAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        add_noise($urandom_range(0, 2));
        add_frame(len - 2);
        made += len;
      end else if (pick < 85) begin
        add_noise($urandom_range(1, 6));
      end else begin
        // A broken header: the first byte followed by a random byte.
        pending_bytes.push_back(hdr_first_cfg);
        pending_bytes.push_back(rand_byte());
      end
    end
    // Sometimes the phase stops inside a frame. The next setting then
    // applies to a frame that is already open.
    if ($urandom_range(0, 1) == 0) add_frame($urandom_range(0, len - 2));
    wait_drained();
  endtask

  initial begin : stimulus
    // Reset values in use: overlapping header, a full frame that carries
    // header bytes in its payload, then a broken header.
    logic [tbhf_pkg::BYTE_W-1:0] reset_run [13] = '{8'h00, 8'hAA, 8'hAA, 8'h55, 8'hFF,
                                                   8'h00, 8'hAA, 8'h55, 8'h12, 8'h34,
                                                   8'hAA, 8'h13, 8'h55};
    // Equal all-ones header bytes with the shortest frame, back to back.
    logic [tbhf_pkg::BYTE_W-1:0] short_run [6] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                                  8'h00};
    // The start of a longer frame. It is left open for a length change.
    logic [tbhf_pkg::BYTE_W-1:0] open_run  [5] = '{8'h00, 8'hC3, 8'h01, 8'h02, 8'h03};
    logic [tbhf_pkg::BYTE_W-1:0] len_plan  [9];
    int                          stage;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (reset_run[i]) pending_bytes.push_back(reset_run[i]);
    wait_drained();

    write_reg(tbhf_pkg::REG_HEADER_FIRST, 8'hFF);
    write_reg(tbhf_pkg::REG_HEADER_SECOND, 8'hFF);
    write_reg(tbhf_pkg::REG_FRAME_LENGTH, 8'd2);
    write_reg(REG_UNUSED, 8'h00);
    foreach (short_run[i]) pending_bytes.push_back(short_run[i]);
    wait_drained();

    // Five bytes are out when the length drops to four, so the next byte
    // has to close the frame.
    write_reg(tbhf_pkg::REG_HEADER_FIRST, 8'h00);
    write_reg(tbhf_pkg::REG_HEADER_SECOND, 8'hC3);
    write_reg(tbhf_pkg::REG_FRAME_LENGTH, 8'd10);
    foreach (open_run[i]) pending_bytes.push_back(open_run[i]);
    wait_drained();
    write_reg(tbhf_pkg::REG_FRAME_LENGTH, 8'd4);
    pending_bytes.push_back(8'h04);
    wait_drained();

    // Length settings per phase. They include values below two, above the
    // maximum, and one with the top data bit set, which is not stored.
    len_plan    = '{8'd3, 8'd0, 8'd5, 8'd127, 8'd1, 8'hC8, 8'd64, 8'd2, 8'd8};
    len_plan[8] = tbhf_pkg::BYTE_W'($urandom_range(2, 16));
    for (stage = 0; stage < 3; stage++) begin
      send_idle_pct = (stage == 0) ? 12 : (stage == 1) ? 73 : 0;
      recv_idle_pct = (stage == 0) ? 73 : (stage == 1) ? 12 : 0;
      for (int k = 0; k < 3; k++)
        run_random_phase(len_plan[stage * 3 + k], stage == 2 && k == 0);
    end

    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
